[design/pls_pkg.sv]
package pls_pkg;

    // List size, its derived index width and the entry count width.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 5;

    // Operation codes.
    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_APPEND = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_UPDATE = 3'd3;
    localparam logic [2:0] FUNC_FIND   = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;

    // Request transaction.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic [7:0]         position;
    } t_req;

    // Response transaction.
    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [CNT_W-1:0] count;
    } t_rsp;

endpackage

[design/positional_list_store.sv]
// Append, update, insert at the end, remove of the last entry, find on an empty list,
// rejected requests and unused codes answer in the cycle after acceptance. Other
// inserts and removes shift entries, and other finds read entries up to the first match.
// Each moved or compared entry costs a read state and a write or compare state; an
// insert then writes its new value in a place state. One request is in progress at a time.
// Reset clears the entry count; memory contents stay undefined until written.
module positional_list_store
    import pls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_MOVE  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    // Entry memory with registered read data.
    logic [31:0] mem [CAPACITY];
    logic [31:0] r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_op, n_op;
    logic [31:0]      r_val, n_val;
    logic [IDX_W-1:0] r_src, n_src;
    logic [IDX_W-1:0] r_dst, n_dst;
    logic [IDX_W-1:0] r_place, n_place;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic             accept;
    logic             out_free;
    logic             full;
    logic [7:0]       cnt8;
    logic [IDX_W-1:0] cnt_idx;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] posm1_idx;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign full      = (r_count >= CNT_W'(CAPACITY));
    assign cnt8      = 8'(r_count);
    assign cnt_idx   = r_count[IDX_W-1:0];
    assign last_idx  = cnt_idx - IDX_W'(1);
    assign pos_idx   = i_in_data.position[IDX_W-1:0];
    assign posm1_idx = pos_idx - IDX_W'(1);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: decode, shift and search steps, and result capture.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_val       = r_val;
        n_src       = r_src;
        n_dst       = r_dst;
        n_place     = r_place;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_dst;
        mem_wdata   = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op        = i_in_data.func;
                    n_val       = i_in_data.value;
                    n_out.status = ST_DONE;
                    n_out.found  = 1'b0;
                    n_out.count  = r_count;
                    n_out_valid  = 1'b1;
                    case (i_in_data.func)
                        FUNC_INSERT: begin
                            if (full) begin
                                n_out.status = ST_FULL;
                            end else if (i_in_data.position == 8'd0 ||
                                         i_in_data.position > cnt8 + 8'd1) begin
                                n_out.status = ST_BADPOS;
                            end else if (i_in_data.position == cnt8 + 8'd1) begin
                                mem_we      = 1'b1;
                                mem_waddr   = cnt_idx;
                                mem_wdata   = i_in_data.value;
                                n_count     = r_count + CNT_W'(1);
                                n_out.count = r_count + CNT_W'(1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_src       = last_idx;
                                n_dst       = cnt_idx;
                                n_place     = posm1_idx;
                                n_state     = S_READ;
                            end
                        end
                        FUNC_APPEND: begin
                            if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = cnt_idx;
                                mem_wdata   = i_in_data.value;
                                n_count     = r_count + CNT_W'(1);
                                n_out.count = r_count + CNT_W'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (i_in_data.position == 8'd0 || i_in_data.position > cnt8) begin
                                n_out.status = ST_BADPOS;
                            end else if (i_in_data.position == cnt8) begin
                                n_count     = r_count - CNT_W'(1);
                                n_out.count = r_count - CNT_W'(1);
                            end else begin
                                n_out_valid = 1'b0;
                                n_src       = pos_idx;
                                n_dst       = posm1_idx;
                                n_state     = S_READ;
                            end
                        end
                        FUNC_UPDATE: begin
                            if (i_in_data.position == 8'd0 || i_in_data.position > cnt8) begin
                                n_out.status = ST_BADPOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = posm1_idx;
                                mem_wdata = i_in_data.value;
                            end
                        end
                        FUNC_FIND: begin
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_src       = '0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                n_state = S_READ;
                case (r_op)
                    FUNC_INSERT: begin
                        // Move one entry up by one place, walking downward.
                        mem_we = 1'b1;
                        if (r_src == r_place) begin
                            n_state = S_PLACE;
                        end else begin
                            n_src = r_src - IDX_W'(1);
                            n_dst = r_dst - IDX_W'(1);
                        end
                    end
                    FUNC_REMOVE: begin
                        // Move one entry down by one place, walking upward.
                        mem_we = 1'b1;
                        if (r_src == last_idx) begin
                            n_state      = S_IDLE;
                            n_count      = r_count - CNT_W'(1);
                            n_out_valid  = 1'b1;
                            n_out.status = ST_DONE;
                            n_out.found  = 1'b0;
                            n_out.count  = r_count - CNT_W'(1);
                        end else begin
                            n_src = r_src + IDX_W'(1);
                            n_dst = r_dst + IDX_W'(1);
                        end
                    end
                    default: begin
                        // Find: compare the entry read in the previous cycle.
                        if (r_rd_data == r_val || r_src == last_idx) begin
                            n_state      = S_IDLE;
                            n_out_valid  = 1'b1;
                            n_out.status = ST_DONE;
                            n_out.found  = (r_rd_data == r_val);
                            n_out.count  = r_count;
                        end else begin
                            n_src = r_src + IDX_W'(1);
                        end
                    end
                endcase
            end
            default: begin
                // Place the new value after the shift has opened its slot.
                mem_we       = 1'b1;
                mem_waddr    = r_place;
                mem_wdata    = r_val;
                n_state      = S_IDLE;
                n_count      = r_count + CNT_W'(1);
                n_out_valid  = 1'b1;
                n_out.status = ST_DONE;
                n_out.found  = 1'b0;
                n_out.count  = r_count + CNT_W'(1);
            end
        endcase
    end

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_src];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Operation context and result payload.
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_val   <= n_val;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_place <= n_place;
        r_out   <= n_out;
    end

endmodule

[sim/tb_positional_list_store.sv]
`timescale 1ns / 100ps

module tb_positional_list_store;
    import pls_pkg::*;

    // Codes the block treats as no operation.
    localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

    localparam int IDLE_PCT       = 29;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int CALM_FROM      = 4000;
    localparam int CALM_TO        = 9000;
    localparam int QUIET_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 100;
    localparam int POOL_DEPTH     = 12;
    localparam int PHASE_LEN      = 150;

    // A request waiting to be offered, optionally held back until the list is quiet.
    typedef struct {
        t_req req;
        bit   drain_first;
    } t_list_request;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp_data;

    t_list_request request_q [$];
    t_rsp          list_answers_due [$];

    // Shadow copy of the list contents.
    logic [31:0] list_vals [CAPACITY];
    int          list_len = 0;

    // Stimulus-side bookkeeping used to aim positions and values.
    int          gen_len = 0;
    logic [31:0] value_pool [$];

    int cycle_cnt  = 0;
    int quiet_cnt  = 0;
    int fail_count = 0;
    bit req_taken  = 1'b0;
    bit rsp_taken  = 1'b0;

    wire calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

    positional_list_store uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one request to the shadow list and return the answer it should produce.
    function automatic t_rsp apply_list_request(t_req r);
        t_rsp a;
        int   p;
        int   k;
        a.status = ST_DONE;
        a.found  = 1'b0;
        p        = r.position;
        case (r.func)
            FUNC_INSERT: begin
                if (list_len >= CAPACITY) begin
                    a.status = ST_FULL;
                end else if (p < 1 || p > list_len + 1) begin
                    a.status = ST_BADPOS;
                end else begin
                    for (k = list_len; k >= p; k--) begin
                        list_vals[k] = list_vals[k-1];
                    end
                    list_vals[p-1] = r.value;
                    list_len++;
                end
            end
            FUNC_APPEND: begin
                if (list_len >= CAPACITY) begin
                    a.status = ST_FULL;
                end else begin
                    list_vals[list_len] = r.value;
                    list_len++;
                end
            end
            FUNC_REMOVE: begin
                if (p < 1 || p > list_len) begin
                    a.status = ST_BADPOS;
                end else begin
                    for (k = p; k < list_len; k++) begin
                        list_vals[k-1] = list_vals[k];
                    end
                    list_len--;
                end
            end
            FUNC_UPDATE: begin
                if (p < 1 || p > list_len) begin
                    a.status = ST_BADPOS;
                end else begin
                    list_vals[p-1] = r.value;
                end
            end
            FUNC_FIND: begin
                for (k = 0; k < list_len; k++) begin
                    if (list_vals[k] == r.value) begin
                        a.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        a.count = CNT_W'(list_len);
        return a;
    endfunction

    // Queue a request and track the list length it leads to, so later positions can aim well.
    task automatic queue_request(logic [2:0] func, logic [31:0] value, int position,
                                 bit drain_first);
        t_list_request item;
        item.req.func     = func;
        item.req.value    = value;
        item.req.position = 8'(position);
        item.drain_first  = drain_first;
        request_q.push_back(item);
        case (func)
            FUNC_INSERT: begin
                if (gen_len < CAPACITY && position >= 1 && position <= gen_len + 1) begin
                    gen_len++;
                end
            end
            FUNC_APPEND: begin
                if (gen_len < CAPACITY) begin
                    gen_len++;
                end
            end
            FUNC_REMOVE: begin
                if (position >= 1 && position <= gen_len) begin
                    gen_len--;
                end
            end
            default: begin
            end
        endcase
        if (func == FUNC_INSERT || func == FUNC_APPEND || func == FUNC_UPDATE) begin
            value_pool.push_back(value);
            if (value_pool.size() > POOL_DEPTH) begin
                value_pool.pop_front();
            end
        end
    endtask

    // Fresh random values or, often, recently written ones so that finds can hit; sometimes extremes.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45 && value_pool.size() > 0) begin
            return value_pool[$urandom_range(value_pool.size() - 1)];
        end else if (roll < 48) begin
            return 32'h8000_0000;
        end else if (roll < 51) begin
            return 32'h7FFF_FFFF;
        end else begin
            return $urandom;
        end
    endfunction

    // Directed requests: empty list, both ends of the list, extreme values, full list.
    task automatic build_directed();
        int n;
        queue_request(FUNC_REMOVE, $urandom, 1, 1'b0);
        queue_request(FUNC_UPDATE, $urandom, 1, 1'b0);
        queue_request(FUNC_FIND, 32'h0, 0, 1'b0);
        queue_request(FUNC_INSERT, $urandom, 0, 1'b0);
        queue_request(FUNC_INSERT, $urandom, 2, 1'b0);
        queue_request(FUNC_INSERT, 32'h8000_0000, 1, 1'b0);
        queue_request(FUNC_APPEND, 32'h7FFF_FFFF, 255, 1'b0);
        queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 3, 1'b0);
        queue_request(FUNC_INSERT, 32'h0, 1, 1'b0);
        queue_request(FUNC_FIND, 32'h8000_0000, 0, 1'b0);
        queue_request(FUNC_FIND, 32'h7FFF_FFFF, 255, 1'b0);
        queue_request(FUNC_FIND, 32'h1234_5678, 1, 1'b0);
        queue_request(FUNC_UPDATE, 32'h5555_5555, 4, 1'b0);
        queue_request(FUNC_UPDATE, 32'hAAAA_AAAA, 5, 1'b0);
        queue_request(FUNC_REMOVE, $urandom, 5, 1'b0);
        queue_request(FUNC_REMOVE, $urandom, 4, 1'b0);
        queue_request(FUNC_REMOVE, $urandom, 1, 1'b0);
        queue_request(FUNC_UNUSED_FIRST, $urandom, $urandom_range(255), 1'b0);
        queue_request(FUNC_UNUSED_LAST, $urandom, $urandom_range(255), 1'b0);
        for (n = gen_len; n < CAPACITY; n++) begin
            queue_request(FUNC_APPEND, $urandom, $urandom_range(255), 1'b0);
        end
        // Full list: the full status wins over a bad position.
        queue_request(FUNC_INSERT, $urandom, 1, 1'b0);
        queue_request(FUNC_INSERT, $urandom, 0, 1'b0);
        queue_request(FUNC_APPEND, $urandom, 0, 1'b0);
        queue_request(FUNC_FIND, value_pool[value_pool.size() - 1], 0, 1'b0);
        queue_request(FUNC_UPDATE, 32'hFFFF_FFFF, CAPACITY, 1'b0);
        queue_request(FUNC_REMOVE, $urandom, 255, 1'b0);
        queue_request(FUNC_REMOVE, $urandom, CAPACITY, 1'b0);
        queue_request(FUNC_INSERT, $urandom, CAPACITY, 1'b0);
    endtask

    // Random requests in alternating growing and shrinking phases, mostly well aimed.
    task automatic build_random();
        int         n;
        int         roll;
        int         pos;
        bit         grow;
        logic [2:0] func;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            grow = ((n / PHASE_LEN) % 2) == 0;
            roll = $urandom_range(99);
            if (roll < 5) begin
                func = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
            end else if (roll < (grow ? 30 : 17)) begin
                func = FUNC_INSERT;
            end else if (roll < (grow ? 55 : 25)) begin
                func = FUNC_APPEND;
            end else if (roll < (grow ? 70 : 65)) begin
                func = FUNC_REMOVE;
            end else if (roll < (grow ? 82 : 80)) begin
                func = FUNC_UPDATE;
            end else begin
                func = FUNC_FIND;
            end
            if ($urandom_range(99) < 15) begin
                pos = $urandom_range(255);
            end else if (func == FUNC_INSERT) begin
                pos = $urandom_range(gen_len + 1, 1);
            end else if (func == FUNC_REMOVE || func == FUNC_UPDATE) begin
                pos = (gen_len > 0) ? $urandom_range(gen_len, 1) : 1;
            end else begin
                pos = $urandom_range(255);
            end
            queue_request(func, pick_value(), pos, n == 0 || n == 700 || n == 1400);
        end
    endtask

    // Driver: offers requests and drives the result stall at the falling edge.
    always @(negedge clk) begin
        bit offer;
        offer = 1'b0;
        if (rst_n) begin
            if (req_valid && !req_taken) begin
                offer = 1'b1;
            end else if (request_q.size() > 0
                         && !(request_q[0].drain_first && list_answers_due.size() != 0)
                         && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                offer = 1'b1;
                req_data <= request_q[0].req;
            end
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
        req_valid <= offer;
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge clk) begin
        t_rsp want;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        if (rst_n) begin
            cycle_cnt++;
            req_taken = req_valid && !req_stall;
            rsp_taken = rsp_valid && !rsp_stall;
            if (req_taken) begin
                list_answers_due.push_back(apply_list_request(req_data));
                request_q.pop_front();
            end
            if (rsp_taken) begin
                if (list_answers_due.size() == 0) begin
                    $error("result transaction with nothing expected: %p", rsp_data);
                    fail_count++;
                end else begin
                    want = list_answers_due.pop_front();
                    if (rsp_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                        fail_count++;
                    end
                    if (rsp_data.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, rsp_data.found);
                        fail_count++;
                    end
                    if (rsp_data.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
                        fail_count++;
                    end
                end
            end
            // Watchdog on cycles without any transaction.
            quiet_cnt = (req_taken || rsp_taken) ? 0 : quiet_cnt + 1;
            if (quiet_cnt >= QUIET_LIMIT) begin
                $display("positional_list_store regression: fail");
                $finish;
            end
        end
    end

    // Build the stimulus, release reset, then wait for the list to go quiet.
    initial begin
        build_directed();
        build_random();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (request_q.size() != 0 || list_answers_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("positional_list_store regression: pass");
        end else begin
            $display("positional_list_store regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
design/pls_pkg.sv
design/positional_list_store.sv
sim/tb_positional_list_store.sv
